// ----- src/pfsa_pkg.sv -----
// ---------------------------------------------------------------------------
// Page frame state allocator package
// Shared state, queue, mode and status codes, register map and helpers.
// ---------------------------------------------------------------------------
package pfsa_pkg;

  // Default frame table depth
  localparam int MAX_PAGES_DEF  = 1024;
  localparam int PAGE_COUNT_RST = 1024;

  // Field widths
  localparam int PAGE_W  = 20;
  localparam int COUNT_W = 11;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // Register indexes
  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // Page states
  localparam int NST = 9;
  localparam logic [3:0] ST_ACTIVE   = 4'd0;
  localparam logic [3:0] ST_INACTIVE = 4'd1;
  localparam logic [3:0] ST_BUSY     = 4'd2;
  localparam logic [3:0] ST_MODIFIED = 4'd3;
  localparam logic [3:0] ST_MODTEMP  = 4'd4;
  localparam logic [3:0] ST_FREE     = 4'd5;
  localparam logic [3:0] ST_CLEAR    = 4'd6;
  localparam logic [3:0] ST_WIRED    = 4'd7;
  localparam logic [3:0] ST_UNUSED   = 4'd8;

  // Queues
  localparam int NQ = 5;
  localparam logic [2:0] Q_FREE    = 3'd0;
  localparam logic [2:0] Q_CLEAR   = 3'd1;
  localparam logic [2:0] Q_ACTIVE  = 3'd2;
  localparam logic [2:0] Q_MOD     = 3'd3;
  localparam logic [2:0] Q_MODTEMP = 3'd4;

  // Request modes
  localparam logic [2:0] MODE_ALLOC = 3'd0;
  localparam logic [2:0] MODE_SPEC  = 3'd1;
  localparam logic [2:0] MODE_SET   = 3'd2;
  localparam logic [2:0] MODE_RANGE = 3'd3;
  localparam logic [2:0] MODE_RUN   = 3'd4;
  localparam logic [2:0] MODE_QUERY = 3'd5;
  localparam logic [2:0] MODE_INIT  = 3'd6;

  // Status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOPAGE = 2'd1;
  localparam logic [1:0] STAT_INVAL  = 2'd2;
  localparam logic [1:0] STAT_BADST  = 2'd3;

  // Queue that holds pages of a given state
  function automatic logic [2:0] queue_of(input logic [3:0] st);
    logic [2:0] q;
    case (st)
      ST_MODIFIED: q = Q_MOD;
      ST_MODTEMP:  q = Q_MODTEMP;
      ST_FREE:     q = Q_FREE;
      ST_CLEAR:    q = Q_CLEAR;
      default:     q = Q_ACTIVE;
    endcase
    return q;
  endfunction

endpackage

// ----- src/pfsa_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// Page frame allocator configuration registers
// APB-style register block holding the base page and the page count.
// ---------------------------------------------------------------------------
module pfsa_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfsa_pkg::CFG_AW-1:0]   paddr,
  input  logic [pfsa_pkg::CFG_DW-1:0]   pwdata,
  output logic [pfsa_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output logic [pfsa_pkg::PAGE_W-1:0]   base_page,
  output logic [pfsa_pkg::COUNT_W-1:0]  page_count
);
  import pfsa_pkg::*;

  logic [PAGE_W-1:0]  base_r;
  logic [COUNT_W-1:0] count_r;
  logic               reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      count_r <= COUNT_W'(PAGE_COUNT_RST);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BASE:  base_r  <= pwdata[PAGE_W-1:0];
        REG_COUNT: count_r <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_BASE:  prdata = CFG_DW'(base_r);
      REG_COUNT: prdata = CFG_DW'(count_r);
      default:   prdata = '0;
    endcase
  end

  assign base_page  = base_r;
  assign page_count = count_r;

endmodule

// ----- src/page_frame_state_allocator.sv -----
// Alloc one, alloc specific and set state run the link update steps (read, unlink,
// enqueue, commit). Range marks run these steps for each page; runs first scan frames
// for a first fit, then run the steps for each claimed page. Query and rejected
// requests go straight to the response. Initialize and reset sweep every entry of the
// frame table; no request is accepted during the sweep after reset. One request is in
// flight at a time.
// ---------------------------------------------------------------------------
// Page frame state allocator
// Tracks the state of each page frame on five linked queues with per-state
// tallies, under a sequencer that drives one shared link update engine.
// ---------------------------------------------------------------------------
module page_frame_state_allocator #(
  parameter int MAX_PAGES = pfsa_pkg::MAX_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // tdata: page_number[19:0], state_code[23:20], run_length[34:24]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [39:0]                   in_tdata,
  // tuser: mode[2:0]
  input  logic [2:0]                    in_tuser,
  // tdata: result_page[19:0], needs_zeroing[20], modified_available[21],
  //        count_value[32:22], free_total[43:33]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [47:0]                   out_tdata,
  // tuser: status[1:0]
  output logic [1:0]                    out_tuser,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pfsa_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [pfsa_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [pfsa_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import pfsa_pkg::*;

  localparam int IW = $clog2(MAX_PAGES + 1);
  localparam int FW = $clog2(MAX_PAGES);
  localparam logic [IW-1:0] LINK_NONE = IW'(MAX_PAGES);
  localparam logic [IW-1:0] MGD_RST   =
    (PAGE_COUNT_RST > MAX_PAGES) ? IW'(MAX_PAGES) : IW'(PAGE_COUNT_RST);
  localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_PAGES - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_INIT   = 4'd2;
  localparam logic [3:0] S_HEAD   = 4'd3;
  localparam logic [3:0] S_HEAD2  = 4'd4;
  localparam logic [3:0] S_CS_RD  = 4'd5;
  localparam logic [3:0] S_CS_OLD = 4'd6;
  localparam logic [3:0] S_UL1    = 4'd7;
  localparam logic [3:0] S_UL2    = 4'd8;
  localparam logic [3:0] S_ENQ    = 4'd9;
  localparam logic [3:0] S_ENQ2   = 4'd10;
  localparam logic [3:0] S_CS_FIN = 4'd11;
  localparam logic [3:0] S_NEXT   = 4'd12;
  localparam logic [3:0] S_SR_RD  = 4'd13;
  localparam logic [3:0] S_SR_CHK = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  // Configuration
  logic [PAGE_W-1:0]  base_page;
  logic [COUNT_W-1:0] page_count;

  pfsa_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .base_page  (base_page),
    .page_count (page_count)
  );

  // Sequencer and request registers
  logic [3:0]         state_r, state_nxt;
  logic               init_rst_r;
  logic [2:0]         mode_r;
  logic [PAGE_W-1:0]  pn_r;
  logic [3:0]         sc_r;
  logic [COUNT_W-1:0] len_r;
  logic [IW-1:0]      cnt_r;
  logic [IW-1:0]      p_r, pr_r, nx_r, h_r, cur_r, start_r, lim_r;
  logic [3:0]         tgt_r;
  logic [2:0]         fq_r, tq_r;
  logic [1:0]         status_r;
  logic [PAGE_W-1:0]  rpage_r;
  logic               zero_r, modav_r;
  logic [COUNT_W-1:0] cval_r;
  logic               out_valid_r;
  logic [47:0]        out_data_r;
  logic [1:0]         out_user_r;

  // Queue heads, lengths and state tallies
  logic [IW-1:0] head_r  [NQ];
  logic [IW-1:0] qlen_r  [NQ];
  logic [IW-1:0] tally_r [NST];

  // Frame table memories
  logic [3:0]    st_mem [MAX_PAGES];
  logic [IW-1:0] nx_mem [MAX_PAGES];
  logic [IW-1:0] pv_mem [MAX_PAGES];
  logic [3:0]    st_rd;
  logic [IW-1:0] nx_rd, pv_rd;
  logic [FW-1:0] rd_addr;
  logic          st_we, nx_we, pv_we;
  logic [FW-1:0] st_wa, nx_wa, pv_wa;
  logic [3:0]    st_wd;
  logic [IW-1:0] nx_wd, pv_wd;

  // Shared datapath signals
  logic [IW-1:0]     mgd;
  logic [2:0]        qsel;
  logic [3:0]        tsel;
  logic [IW-1:0]     head_q, len_q, tally_q;
  logic              pn_below, pn_in, range_bad, fit_bad, linked;
  logic [PAGE_W-1:0] pn_off;
  logic [IW-1:0]     cur_inc, run_lim;
  logic              ok_spec, ok_range, skip_spec, skip_range, st_bad;
  logic [2:0]        fq_c, tq_c, pref_q, other_q;

  assign mgd = (32'(page_count) > 32'(MAX_PAGES)) ? LINK_NONE : IW'(page_count);

  // Page lookup and bound checks
  assign pn_below  = pn_r < base_page;
  assign pn_off    = pn_r - base_page;
  assign pn_in     = !pn_below && (pn_off < PAGE_W'(cnt_r));
  assign range_bad = pn_below ||
                     ((21'(pn_off) + 21'(len_r)) > 21'(cnt_r));
  assign fit_bad   = (21'(start_r) + 21'(len_r)) > 21'(cnt_r);
  assign run_lim   = IW'(21'(start_r) + 21'(len_r));
  assign cur_inc   = cur_r + 1'b1;

  // Old state classification
  assign ok_range   = (st_rd == ST_FREE) || (st_rd == ST_CLEAR);
  assign ok_spec    = ok_range || (st_rd == ST_UNUSED);
  assign skip_spec  = (mode_r == MODE_SPEC) && !ok_spec;
  assign skip_range = (mode_r == MODE_RANGE) && !ok_range;
  assign st_bad     = !ok_range;
  assign fq_c       = queue_of(st_rd);
  assign tq_c       = queue_of(tgt_r);
  assign pref_q     = (sc_r == ST_FREE) ? Q_FREE : Q_CLEAR;
  assign other_q    = (sc_r == ST_FREE) ? Q_CLEAR : Q_FREE;

  // Select the queue and tally touched this cycle
  always_comb begin
    unique case (state_r)
      S_HEAD:  qsel = pref_q;
      S_HEAD2: qsel = other_q;
      S_ENQ:   qsel = tq_r;
      default: qsel = fq_r;
    endcase
    unique case (state_r)
      S_CS_OLD: tsel = st_rd;
      S_CS_FIN: tsel = tgt_r;
      default:  tsel = sc_r;
    endcase
  end

  assign head_q  = head_r[qsel];
  assign len_q   = qlen_r[qsel];
  assign tally_q = (tsel < 4'(NST)) ? tally_r[tsel] : '0;
  assign linked  = (pr_r != LINK_NONE) || (head_q == p_r);

  // Memory port control
  always_comb begin
    rd_addr = (state_r == S_SR_RD) ? cur_r[FW-1:0] : p_r[FW-1:0];
    st_we = 1'b0; st_wa = p_r[FW-1:0]; st_wd = tgt_r;
    nx_we = 1'b0; nx_wa = p_r[FW-1:0]; nx_wd = head_q;
    pv_we = 1'b0; pv_wa = p_r[FW-1:0]; pv_wd = LINK_NONE;
    unique case (state_r)
      S_UL1: begin
        nx_we = pr_r != LINK_NONE;
        nx_wa = pr_r[FW-1:0];
        nx_wd = nx_r;
      end
      S_UL2: begin
        pv_we = 1'b1;
        pv_wa = nx_r[FW-1:0];
        pv_wd = pr_r;
      end
      S_ENQ: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
      end
      S_ENQ2: begin
        pv_we = 1'b1;
        pv_wa = h_r[FW-1:0];
        pv_wd = p_r;
      end
      S_CS_FIN: begin
        st_we = 1'b1;
      end
      S_INIT: begin
        st_we = 1'b1;
        nx_we = 1'b1;
        pv_we = 1'b1;
        st_wa = cur_r[FW-1:0];
        nx_wa = cur_r[FW-1:0];
        pv_wa = cur_r[FW-1:0];
        st_wd = (cur_r < cnt_r) ? ST_FREE : ST_UNUSED;
        nx_wd = (cur_r < cnt_r && cur_r != '0) ? cur_r - 1'b1 : LINK_NONE;
        pv_wd = (cur_inc < cnt_r) ? cur_inc : LINK_NONE;
      end
      default: ;
    endcase
  end

  // Frame table storage with registered reads
  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    st_rd <= st_mem[rd_addr];
    nx_rd <= nx_mem[rd_addr];
    pv_rd <= pv_mem[rd_addr];
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_DISP;
      S_DISP: begin
        unique case (mode_r)
          MODE_ALLOC: state_nxt = (sc_r != ST_FREE && sc_r != ST_CLEAR) ? S_DONE : S_HEAD;
          MODE_SPEC:  state_nxt = pn_in ? S_CS_RD : S_DONE;
          MODE_SET:   state_nxt = (pn_in && sc_r <= ST_UNUSED) ? S_CS_RD : S_DONE;
          MODE_RANGE: state_nxt = (range_bad || len_r == '0) ? S_DONE : S_CS_RD;
          MODE_RUN:   state_nxt = (len_r == '0) ? S_DONE : S_SR_RD;
          MODE_INIT:  state_nxt = S_INIT;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_INIT:   if (cur_r == LAST_IDX) state_nxt = init_rst_r ? S_IDLE : S_DONE;
      S_HEAD:   state_nxt = (head_q != LINK_NONE) ? S_CS_RD : S_HEAD2;
      S_HEAD2:  state_nxt = (head_q != LINK_NONE) ? S_CS_RD : S_DONE;
      S_CS_RD:  state_nxt = S_CS_OLD;
      S_CS_OLD: begin
        if (skip_spec)         state_nxt = S_DONE;
        else if (skip_range)   state_nxt = S_NEXT;
        else if (fq_c == tq_c) state_nxt = S_CS_FIN;
        else                   state_nxt = S_UL1;
      end
      S_UL1:    state_nxt = (linked && nx_r != LINK_NONE) ? S_UL2 : S_ENQ;
      S_UL2:    state_nxt = S_ENQ;
      S_ENQ:    state_nxt = (head_q != LINK_NONE) ? S_ENQ2 : S_CS_FIN;
      S_ENQ2:   state_nxt = S_CS_FIN;
      S_CS_FIN: state_nxt = (mode_r == MODE_RANGE || mode_r == MODE_RUN) ? S_NEXT : S_DONE;
      S_NEXT:   state_nxt = (cur_inc == lim_r) ? S_DONE : S_CS_RD;
      S_SR_RD:  state_nxt = fit_bad ? S_DONE : S_SR_CHK;
      S_SR_CHK: state_nxt = (!st_bad && cur_inc == run_lim) ? S_CS_RD : S_SR_RD;
      S_DONE:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_rst_r  <= 1'b1;
      cur_r       <= '0;
      cnt_r       <= MGD_RST;
      out_valid_r <= 1'b0;
      for (int q = 0; q < NQ; q++) begin
        head_r[q] <= LINK_NONE;
        qlen_r[q] <= '0;
      end
      for (int s = 0; s < NST; s++) tally_r[s] <= '0;
      head_r[Q_FREE]   <= (MGD_RST == '0) ? LINK_NONE : MGD_RST - 1'b1;
      qlen_r[Q_FREE]   <= MGD_RST;
      tally_r[ST_FREE] <= MGD_RST;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r     <= in_tuser;
            pn_r       <= in_tdata[19:0];
            sc_r       <= in_tdata[23:20];
            len_r      <= in_tdata[34:24];
            cnt_r      <= mgd;
            status_r   <= STAT_OK;
            rpage_r    <= '0;
            zero_r     <= 1'b0;
            modav_r    <= 1'b0;
            cval_r     <= '0;
            init_rst_r <= 1'b0;
          end
        end
        S_DISP: begin
          unique case (mode_r)
            MODE_ALLOC: begin
              if (sc_r != ST_FREE && sc_r != ST_CLEAR) status_r <= STAT_INVAL;
            end
            MODE_SPEC: begin
              if (!pn_in) status_r <= STAT_INVAL;
              p_r   <= IW'(pn_off);
              tgt_r <= ST_BUSY;
            end
            MODE_SET: begin
              if (!pn_in)                status_r <= STAT_INVAL;
              else if (sc_r > ST_UNUSED) status_r <= STAT_BADST;
              p_r   <= IW'(pn_off);
              tgt_r <= sc_r;
            end
            MODE_RANGE: begin
              if (range_bad) status_r <= STAT_INVAL;
              else           cval_r   <= len_r;
              p_r   <= IW'(pn_off);
              cur_r <= IW'(pn_off);
              lim_r <= IW'(21'(pn_off) + 21'(len_r));
              tgt_r <= ST_UNUSED;
            end
            MODE_RUN: begin
              if (len_r == '0) status_r <= STAT_INVAL;
              start_r <= '0;
              cur_r   <= '0;
            end
            MODE_QUERY: begin
              if (sc_r > ST_UNUSED) status_r <= STAT_BADST;
              else                  cval_r   <= COUNT_W'(tally_q);
            end
            MODE_INIT: begin
              cur_r <= '0;
              for (int q = 0; q < NQ; q++) begin
                head_r[q] <= LINK_NONE;
                qlen_r[q] <= '0;
              end
              for (int s = 0; s < NST; s++) tally_r[s] <= '0;
              head_r[Q_FREE]   <= (cnt_r == '0) ? LINK_NONE : cnt_r - 1'b1;
              qlen_r[Q_FREE]   <= cnt_r;
              tally_r[ST_FREE] <= cnt_r;
            end
            default: status_r <= STAT_INVAL;
          endcase
        end
        S_INIT: cur_r <= cur_inc;
        // Take the head of the preferred queue, then of the other
        S_HEAD, S_HEAD2: begin
          p_r   <= head_q;
          tgt_r <= ST_BUSY;
          if (state_r == S_HEAD2 && head_q == LINK_NONE) status_r <= STAT_NOPAGE;
        end
        S_CS_RD: ;
        // Latch links, flag zeroing and drop the old tally
        S_CS_OLD: begin
          pr_r <= pv_rd;
          nx_r <= nx_rd;
          fq_r <= fq_c;
          tq_r <= tq_c;
          if (skip_spec) begin
            status_r <= STAT_NOPAGE;
          end else if (!skip_range) begin
            if (mode_r == MODE_ALLOC && sc_r == ST_CLEAR && st_rd == ST_FREE)
              zero_r <= 1'b1;
            if (mode_r == MODE_SPEC && sc_r == ST_CLEAR &&
                (st_rd == ST_FREE || st_rd == ST_UNUSED))
              zero_r <= 1'b1;
            if (st_rd < 4'(NST) && tally_q != '0) tally_r[tsel] <= tally_q - 1'b1;
          end
        end
        // Unlink from the old queue
        S_UL1: begin
          if (linked) begin
            if (pr_r == LINK_NONE) head_r[fq_r] <= nx_r;
            if (len_q != '0)       qlen_r[fq_r] <= len_q - 1'b1;
          end
        end
        S_UL2: ;
        // Push onto the head of the new queue
        S_ENQ: begin
          head_r[tq_r] <= p_r;
          qlen_r[tq_r] <= len_q + 1'b1;
          h_r          <= head_q;
          if ((tq_r == Q_MOD || tq_r == Q_MODTEMP) && len_q == '0) modav_r <= 1'b1;
        end
        S_ENQ2: ;
        // Commit the new state and tally
        S_CS_FIN: begin
          tally_r[tsel] <= tally_q + 1'b1;
          if (mode_r == MODE_ALLOC) rpage_r <= base_page + PAGE_W'(p_r);
          if (mode_r == MODE_SPEC)  rpage_r <= pn_r;
        end
        S_NEXT: begin
          cur_r <= cur_inc;
          p_r   <= cur_inc;
          if (mode_r == MODE_RUN) rpage_r <= base_page + PAGE_W'(start_r);
        end
        S_SR_RD: begin
          if (fit_bad) status_r <= STAT_NOPAGE;
        end
        // First-fit scan: restart past a taken frame
        S_SR_CHK: begin
          cur_r <= cur_inc;
          if (st_bad) begin
            start_r <= cur_inc;
          end else if (cur_inc == run_lim) begin
            lim_r <= run_lim;
            p_r   <= start_r;
            cur_r <= start_r;
            tgt_r <= ST_BUSY;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= status_r;
            out_data_r  <= {4'b0, COUNT_W'(qlen_r[Q_FREE] + qlen_r[Q_CLEAR]),
                            cval_r, modav_r, zero_r, rpage_r};
          end
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Checks
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  a_enq_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENQ) |-> (tq_r != fq_r))
    else $error("enqueue onto the queue the frame already sits on");

  a_frame_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CS_RD) |-> (p_r < LINK_NONE))
    else $error("state change on a null frame index");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(qlen_r[Q_FREE]) + 32'(qlen_r[Q_CLEAR])) <= 32'(MAX_PAGES))
    else $error("free and clear queues exceed the frame table");

endmodule
